@@ src/mtv_pkg.sv @@
// shared types, constants and lookup functions for the marching tetrahedra voxel core
// no dependencies, compiled first
package mtv_pkg;

	localparam int unsigned COORD_W  = 10;
	localparam int unsigned NUM_TETS = 6;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QAW      = $clog2(QDEPTH);
	localparam int unsigned QCW      = $clog2(QDEPTH + 1);

	localparam logic [1:0] LAST_SLOT = 2'd2;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [3:0]         case_idx_t;
	typedef logic [2:0]         corner_t;
	typedef logic [2:0]         tet_idx_t;

	// one classified voxel waiting for the back end
	typedef struct packed {
		logic [NUM_TETS-1:0][3:0] cases;
		logic [NUM_TETS-1:0]      active;
		coord_t                   x;
		coord_t                   y;
		coord_t                   z;
	} mtv_entry_t;

	// corners around the 0-7 diagonal
	function automatic corner_t ring_corner(input logic [2:0] i);
		corner_t c;
		unique case (i)
			3'd0:    c = 3'd6;
			3'd1:    c = 3'd4;
			3'd2:    c = 3'd5;
			3'd3:    c = 3'd1;
			3'd4:    c = 3'd3;
			3'd5:    c = 3'd2;
			default: c = 3'd6;
		endcase
		return c;
	endfunction

	function automatic corner_t tet_corner(input tet_idx_t t, input logic [1:0] j);
		corner_t c;
		unique case (j)
			2'd0:    c = 3'd0;
			2'd1:    c = 3'd7;
			2'd2:    c = ring_corner(t);
			default: c = ring_corner(3'(t + 3'd1));
		endcase
		return c;
	endfunction

	function automatic logic [1:0] case_tris(input case_idx_t idx);
		logic [1:0] n;
		unique case (idx)
			4'd0, 4'd15:                          n = 2'd0;
			4'd1, 4'd2, 4'd4, 4'd7, 4'd8, 4'd11,
			4'd13, 4'd14:                         n = 2'd1;
			default:                              n = 2'd2;
		endcase
		return n;
	endfunction

	// six nibbles {a, b}, triangle 0 vertex 0 in the top nibble
	function automatic logic [23:0] case_edges(input case_idx_t idx);
		logic [23:0] e;
		unique case (idx)
			4'd1:    e = 24'h213000;
			4'd2:    e = 24'h674000;
			4'd3:    e = 24'h673326;
			4'd4:    e = 24'h8B9000;
			4'd5:    e = 24'h3B9913;
			4'd6:    e = 24'h8B4B74;
			4'd7:    e = 24'hB73000;
			4'd8:    e = 24'hCDE000;
			4'd9:    e = 24'hE21DE1;
			4'd10:   e = 24'h6ECC46;
			4'd11:   e = 24'h6E2000;
			4'd12:   e = 24'hCD998C;
			4'd13:   e = 24'hD91000;
			4'd14:   e = 24'hC48000;
			default: e = 24'h000000;
		endcase
		return e;
	endfunction

endpackage

@@ src/mtv_if.sv @@
// valid/ready channels for voxels in and edge vertices out
// depends on mtv_pkg
interface mtv_voxel_if;
	logic            valid;
	logic            ready;
	logic [7:0]      inside_mask;
	mtv_pkg::coord_t voxel_x;
	mtv_pkg::coord_t voxel_y;
	mtv_pkg::coord_t voxel_z;

	modport source (output valid, inside_mask, voxel_x, voxel_y, voxel_z, input ready);
	modport sink (input valid, inside_mask, voxel_x, voxel_y, voxel_z, output ready);
endinterface

interface mtv_vertex_if;
	logic            valid;
	logic            ready;
	logic [2:0]      corner_from;
	logic [2:0]      corner_to;
	logic [2:0]      tet_number;
	logic            tri_in_tet;
	logic [1:0]      vertex_slot;
	mtv_pkg::coord_t out_x;
	mtv_pkg::coord_t out_y;
	mtv_pkg::coord_t out_z;
	logic            last;

	modport source (output valid, corner_from, corner_to, tet_number, tri_in_tet,
		vertex_slot, out_x, out_y, out_z, last, input ready);
	modport sink (input valid, corner_from, corner_to, tet_number, tri_in_tet,
		vertex_slot, out_x, out_y, out_z, last, output ready);
endinterface

@@ src/marching_tetrahedra_voxel_core.sv @@
// Marching tetrahedra voxel core: voxel corner masks in, crossing-edge vertices out.
// Channel voxel takes inside_mask and voxel_x/y/z; channel vertex gives one edge
// vertex per transfer (corner pair, tetrahedron, triangle, slot, coordinates, last).
// A voxel is accepted whenever the 4-entry queue has room; the front end looks up
// the six tetrahedron cases in the cycle of the transfer and drops uniform voxels.
// The back end sends one vertex per cycle from the head of the queue while vertex is
// not stalled, so a voxel occupies it for three vertices per triangle (up to 12
// triangles, 36 vertices); that walk sets the sustained rate.
// A transferred voxel is written into the queue; the back end then loads its first
// vertex into the output register, where it is held until vertex.ready.
// A stall on vertex holds the output register; the back end waits, the queue fills,
// and only then is voxel.ready dropped.
// Reset (arst_n low) empties the queue and the output register; no clearing pass.
// depends on mtv_pkg, mtv_if, mtv_front, mtv_queue, mtv_back
module marching_tetrahedra_voxel_core (
	input  logic          clk,
	input  logic          arst_n,
	mtv_voxel_if.sink     voxel,
	mtv_vertex_if.source  vertex
);

	mtv_pkg::mtv_entry_t wr_entry;
	mtv_pkg::mtv_entry_t head;
	logic                push;
	logic                pop;
	logic                full;
	logic                head_valid;

	mtv_front u_front (
		.voxel (voxel),
		.full  (full),
		.push  (push),
		.entry (wr_entry)
	);

	mtv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (wr_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	mtv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.vertex     (vertex)
	);

endmodule

@@ src/mtv_front.sv @@
// front end: accepts voxels and looks up the case of each tetrahedron
// depends on mtv_pkg and mtv_if
module mtv_front (
	mtv_voxel_if.sink          voxel,
	input  logic               full,
	output logic               push,
	output mtv_pkg::mtv_entry_t entry
);

	always_comb begin
		entry   = '0;
		entry.x = voxel.voxel_x;
		entry.y = voxel.voxel_y;
		entry.z = voxel.voxel_z;
		for (int t = 0; t < mtv_pkg::NUM_TETS; t++) begin
			for (int j = 0; j < 4; j++) begin
				entry.cases[t][j] = voxel.inside_mask[mtv_pkg::tet_corner(3'(t), 2'(j))];
			end
			entry.active[t] = mtv_pkg::case_tris(entry.cases[t]) != 2'd0;
		end
	end

	assign voxel.ready = !full;
	// uniform voxels are dropped here
	assign push = voxel.valid && !full && (|entry.active);

endmodule

@@ src/mtv_queue.sv @@
// short queue of classified voxels between front and back end
// depends on mtv_pkg
module mtv_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mtv_pkg::mtv_entry_t wr_entry,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output mtv_pkg::mtv_entry_t head
);

	mtv_pkg::mtv_entry_t          mem_q [mtv_pkg::QDEPTH];
	logic [mtv_pkg::QAW-1:0]      wr_ptr_q;
	logic [mtv_pkg::QAW-1:0]      rd_ptr_q;
	logic [mtv_pkg::QCW-1:0]      count_q;
	logic                         do_pop;

	assign full       = count_q == mtv_pkg::QCW'(mtv_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/mtv_back.sv @@
// back end: walks tetrahedra, triangles and vertices of the head voxel, one vertex a cycle
// while vertex is not stalled; depends on mtv_pkg and mtv_if
module mtv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  mtv_pkg::mtv_entry_t head,
	output logic                pop,
	mtv_vertex_if.source        vertex
);

	logic                  started_q;
	mtv_pkg::tet_idx_t     tet_q;
	logic                  tri_q;
	logic [1:0]            vert_q;

	logic                  out_valid_q;
	mtv_pkg::corner_t      from_q;
	mtv_pkg::corner_t      to_q;
	mtv_pkg::tet_idx_t     tet_out_q;
	logic                  tri_out_q;
	logic [1:0]            slot_q;
	mtv_pkg::coord_t       x_q;
	mtv_pkg::coord_t       y_q;
	mtv_pkg::coord_t       z_q;
	logic                  last_q;

	mtv_pkg::tet_idx_t     first_tet;
	mtv_pkg::tet_idx_t     cur_tet;
	mtv_pkg::tet_idx_t     nxt_tet;
	logic                  nxt_found;
	mtv_pkg::case_idx_t    cur_case;
	logic [1:0]            tris;
	logic [23:0]           edges;
	logic [2:0]            sel;
	logic [3:0]            nib;
	logic                  tri_last;
	logic                  last_n;
	logic                  emit;

	always_comb begin
		first_tet = '0;
		for (int t = mtv_pkg::NUM_TETS - 1; t >= 0; t--) begin
			if (head.active[t]) begin
				first_tet = 3'(t);
			end
		end
		cur_tet  = started_q ? tet_q : first_tet;
		cur_case = '0;
		for (int t = 0; t < mtv_pkg::NUM_TETS; t++) begin
			if (cur_tet == 3'(t)) begin
				cur_case = head.cases[t];
			end
		end
		nxt_found = 1'b0;
		nxt_tet   = '0;
		for (int t = mtv_pkg::NUM_TETS - 1; t >= 0; t--) begin
			if (head.active[t] && 3'(t) > cur_tet) begin
				nxt_found = 1'b1;
				nxt_tet   = 3'(t);
			end
		end
	end

	assign tris     = mtv_pkg::case_tris(cur_case);
	assign edges    = mtv_pkg::case_edges(cur_case);
	assign sel      = tri_q ? 3'(3'd3 + {1'b0, vert_q}) : {1'b0, vert_q};
	assign nib      = edges[5'(3'd5 - sel) * 5'd4 +: 4];
	assign tri_last = (tris == 2'd2) ? tri_q : 1'b1;
	assign last_n   = (vert_q == mtv_pkg::LAST_SLOT) && tri_last && !nxt_found;
	assign emit     = head_valid && (!out_valid_q || vertex.ready);
	assign pop      = emit && last_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			tet_q       <= '0;
			tri_q       <= 1'b0;
			vert_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				priority if (vert_q != mtv_pkg::LAST_SLOT) begin
					started_q <= 1'b1;
					tet_q     <= cur_tet;
					vert_q    <= vert_q + 1'b1;
				end else if (!tri_last) begin
					started_q <= 1'b1;
					tet_q     <= cur_tet;
					tri_q     <= 1'b1;
					vert_q    <= '0;
				end else if (nxt_found) begin
					started_q <= 1'b1;
					tet_q     <= nxt_tet;
					tri_q     <= 1'b0;
					vert_q    <= '0;
				end else begin
					started_q <= 1'b0;
					tri_q     <= 1'b0;
					vert_q    <= '0;
				end
			end else if (vertex.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			from_q    <= mtv_pkg::tet_corner(cur_tet, nib[3:2]);
			to_q      <= mtv_pkg::tet_corner(cur_tet, nib[1:0]);
			tet_out_q <= cur_tet;
			tri_out_q <= tri_q;
			slot_q    <= vert_q;
			x_q       <= head.x;
			y_q       <= head.y;
			z_q       <= head.z;
			last_q    <= last_n;
		end
	end

	assign vertex.valid       = out_valid_q;
	assign vertex.corner_from = from_q;
	assign vertex.corner_to   = to_q;
	assign vertex.tet_number  = tet_out_q;
	assign vertex.tri_in_tet  = tri_out_q;
	assign vertex.vertex_slot = slot_q;
	assign vertex.out_x       = x_q;
	assign vertex.out_y       = y_q;
	assign vertex.out_z       = z_q;
	assign vertex.last        = last_q;

`ifndef SYNTHESIS
	a_mid_voxel_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("head voxel lost in the middle of its walk");
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> (tet_q <= 3'd5 && vert_q != 2'd3))
		else $error("walk counters out of range");
	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !last_n) |=> (started_q && out_valid_q))
		else $error("walk stopped before the last vertex");
`endif

endmodule
